FILE: sv/bbsa_pkg.sv
// Package of shared constants and types for the summed-area box blur unit.
package bbsa_pkg;
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int MAX_WINDOW_DEF = 200;
	localparam int SUM_W = 24;
	localparam int PIX_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic start;
		logic [SUM_W-1:0] dividend;
		logic [SUM_W-1:0] divisor;
	} div_req_t;
endpackage

FILE: sv/box_blur_summed_area_unit.sv
// Top level of the summed-area box blur unit.
// A load reads the entry above, then writes the new sum. A query reads the four
// window corners and the alpha from the single-read-port sum memory, then runs
// each of the three colour sums through the shared bit-serial divider (a start
// state, then a wait for its done pulse), then loads the result register.
// One request is in work at a time; the input is stalled while a request is in
// work and while a finished result is itself stalled at the output.
// The sum memories are not cleared; query only after a full image has been loaded.
module box_blur_summed_area_unit #(
	parameter int MAX_WIDTH  = bbsa_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bbsa_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_WINDOW = bbsa_pkg::MAX_WINDOW_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [bbsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bbsa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic req_type,
	input  logic [7:0] pixel_red,
	input  logic [7:0] pixel_green,
	input  logic [7:0] pixel_blue,
	input  logic [7:0] pixel_alpha,
	input  logic [7:0] query_row,
	input  logic [7:0] query_col,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] blur_red,
	output logic [7:0] blur_green,
	output logic [7:0] blur_blue,
	output logic [7:0] kept_alpha,
	output logic query_error
);
	localparam int SW = bbsa_pkg::SUM_W;
	localparam int CB = $clog2(MAX_WIDTH) > 0 ? $clog2(MAX_WIDTH) : 1;
	localparam int RB = $clog2(MAX_HEIGHT) > 0 ? $clog2(MAX_HEIGHT) : 1;
	localparam int AB = CB + RB;
	localparam int DEPTH = 1 << AB;
	localparam int DW = 13;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001, S_LRD  = 9'b000000010, S_LWR = 9'b000000100,
		S_QRD  = 9'b000001000, S_QWT  = 9'b000010000, S_DIV = 9'b000100000,
		S_DWT  = 9'b001000000, S_OUT  = 9'b010000000, S_ERR = 9'b100000000
	} state_t;

	state_t state_q;
	logic [8:0] width_q, height_q;
	logic [7:0] window_q;
	logic [DW-1:0] w_e, h_e, s_e;

	always_comb begin
		w_e = (width_q == '0) ? DW'(1) : (DW'(width_q) > DW'(MAX_WIDTH) ? DW'(MAX_WIDTH)
			: DW'(width_q));
		h_e = (height_q == '0) ? DW'(1) : (DW'(height_q) > DW'(MAX_HEIGHT) ? DW'(MAX_HEIGHT)
			: DW'(height_q));
		s_e = (window_q == '0) ? DW'(1) : (DW'(window_q) > DW'(MAX_WINDOW) ? DW'(MAX_WINDOW)
			: DW'(window_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd256;
			height_q <= 9'd256;
			window_q <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				bbsa_pkg::REG_WIDTH:  width_q <= cfg_data;
				bbsa_pkg::REG_HEIGHT: height_q <= cfg_data;
				bbsa_pkg::REG_WINDOW: window_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Sum memories: R, G, B packed in one word, and alpha beside them.
	logic [3*SW-1:0] sum_mem [DEPTH];
	logic [7:0] alpha_mem [DEPTH];
	logic [AB-1:0] rd_addr, wr_addr;
	logic rd_en, wr_en;
	logic [3*SW-1:0] rd_data, wr_data;
	logic [7:0] alpha_rd, wr_alpha;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			sum_mem[wr_addr] <= wr_data;
			alpha_mem[wr_addr] <= wr_alpha;
		end
		if (rd_en) begin
			rd_data <= sum_mem[rd_addr];
			alpha_rd <= alpha_mem[rd_addr];
		end
	end

	logic [DW-1:0] lrow_q, lcol_q;
	logic [SW-1:0] run_q [3];
	logic [7:0] px_q [4];
	logic [DW-1:0] qr_q, qc_q, r0_q, r1_q, c0_q, c1_q;
	logic [2:0] ci_q;
	logic [SW-1:0] acc_q [3];
	logic [SW-1:0] ndiv_q;
	logic [1:0] ch_q;
	logic [7:0] res_q [3];
	logic [7:0] alpha_q;
	logic use_q;
	logic accept;
	logic [DW-1:0] lr_eff, lc_eff;
	logic lout;

	assign in_stall = !(state_q == S_IDLE) || (out_valid && out_stall);
	assign accept = in_valid && !in_stall;
	assign lout = (lrow_q >= h_e) || (lcol_q >= w_e);
	assign lr_eff = lout ? '0 : lrow_q;
	assign lc_eff = lout ? '0 : lcol_q;

	bbsa_pkg::div_req_t dreq;
	logic dbusy, ddone;
	logic [SW-1:0] dquo;
	bbsa_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .busy(dbusy),
		.done(ddone), .quotient(dquo));
	assign dreq.divisor = ndiv_q;
	assign dreq.dividend = acc_q[ch_q];
	assign dreq.start = (state_q == S_DIV);

	// Corner selection: 0 = (r1,c1), 1 = (r1,c0-1), 2 = (r0-1,c1), 3 = (r0-1,c0-1), 4 = alpha.
	logic [DW-1:0] cr, cc;
	logic cuse;
	always_comb begin
		cr = r1_q; cc = c1_q; cuse = 1'b1;
		case (ci_q)
			3'd0: begin cr = r1_q; cc = c1_q; end
			3'd1: begin cr = r1_q; cc = c0_q - 1'b1; cuse = (c0_q != '0); end
			3'd2: begin cr = r0_q - 1'b1; cc = c1_q; cuse = (r0_q != '0); end
			3'd3: begin cr = r0_q - 1'b1; cc = c0_q - 1'b1;
				cuse = (r0_q != '0) && (c0_q != '0); end
			default: begin cr = qr_q; cc = qc_q; end
		endcase
	end

	always_comb begin
		rd_en = 1'b0;
		rd_addr = {lr_eff[RB-1:0] - 1'b1, lc_eff[CB-1:0]};
		if (state_q == S_LRD) rd_en = 1'b1;
		if (state_q == S_QRD) begin
			rd_en = 1'b1;
			rd_addr = {cr[RB-1:0], cc[CB-1:0]};
		end
		wr_en = (state_q == S_LWR);
		wr_addr = {lr_eff[RB-1:0], lc_eff[CB-1:0]};
		wr_alpha = px_q[3];
		for (int k = 0; k < 3; k++) begin
			wr_data[k*SW +: SW] = ((lc_eff == '0) ? SW'(px_q[k]) : run_q[k] + SW'(px_q[k]))
				+ ((lr_eff != '0) ? rd_data[k*SW +: SW] : '0);
		end
	end

	logic [DW-1:0] r0n, c0n, r1n, c1n;
	logic [DW-1:0] tr, tc;
	always_comb begin
		tr = DW'(query_row); tc = DW'(query_col);
		r0n = (tr + 1'b1 > s_e) ? tr + 1'b1 - s_e : '0;
		c0n = (tc + 1'b1 > s_e) ? tc + 1'b1 - s_e : '0;
		r1n = (tr + s_e - 1'b1 < h_e) ? tr + s_e - 1'b1 : h_e - 1'b1;
		c1n = (tc + s_e - 1'b1 < w_e) ? tc + s_e - 1'b1 : w_e - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lrow_q <= '0;
			lcol_q <= '0;
			out_valid <= 1'b0;
			for (int k = 0; k < 3; k++) run_q[k] <= '0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (accept) begin
					if (req_type == bbsa_pkg::REQ_LOAD) state_q <= S_LRD;
					else if (DW'(query_row) >= h_e || DW'(query_col) >= w_e) state_q <= S_ERR;
					else state_q <= S_QRD;
				end
				S_LRD: state_q <= S_LWR;
				S_LWR: begin
					for (int k = 0; k < 3; k++)
						run_q[k] <= (lc_eff == '0) ? SW'(px_q[k]) : run_q[k] + SW'(px_q[k]);
					if (lc_eff + 1'b1 >= w_e) begin
						lcol_q <= '0;
						lrow_q <= (lr_eff + 1'b1 >= h_e) ? '0 : lr_eff + 1'b1;
					end else begin
						lcol_q <= lc_eff + 1'b1;
						lrow_q <= lr_eff;
					end
					state_q <= S_IDLE;
				end
				S_QRD: if (ci_q == 3'd4) state_q <= S_QWT;
				S_QWT: state_q <= S_DIV;
				S_DIV: state_q <= S_DWT;
				S_DWT: if (ddone) state_q <= (ch_q == 2'd2) ? S_OUT : S_DIV;
				S_OUT, S_ERR: begin
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (accept) begin
				px_q[0] <= pixel_red; px_q[1] <= pixel_green;
				px_q[2] <= pixel_blue; px_q[3] <= pixel_alpha;
				qr_q <= DW'(query_row); qc_q <= DW'(query_col);
				r0_q <= r0n; r1_q <= r1n; c0_q <= c0n; c1_q <= c1n;
				ci_q <= '0;
				ch_q <= '0;
				use_q <= 1'b0;
				for (int k = 0; k < 3; k++) acc_q[k] <= '0;
			end
			S_QRD, S_QWT: begin
				if (state_q == S_QRD) ci_q <= ci_q + 1'b1;
				use_q <= cuse;
				// A full-image window holds up to 65536 pixels, so the count needs the sum width.
				ndiv_q <= SW'(r1_q - r0_q + 1'b1) * SW'(c1_q - c0_q + 1'b1);
				// Data read in the previous cycle belongs to corner ci_q-1.
				if (state_q == S_QRD && ci_q != 3'd0 && use_q) begin
					for (int k = 0; k < 3; k++)
						acc_q[k] <= (ci_q == 3'd2 || ci_q == 3'd3)
							? acc_q[k] - rd_data[k*SW +: SW]
							: acc_q[k] + rd_data[k*SW +: SW];
				end
				if (state_q == S_QWT) alpha_q <= alpha_rd;
			end
			S_DWT: if (ddone) begin
				res_q[ch_q] <= dquo[7:0];
				ch_q <= ch_q + 1'b1;
			end
			S_OUT: begin
				blur_red <= res_q[0]; blur_green <= res_q[1]; blur_blue <= res_q[2];
				kept_alpha <= alpha_q; query_error <= 1'b0;
			end
			S_ERR: begin
				blur_red <= '0; blur_green <= '0; blur_blue <= '0;
				kept_alpha <= '0; query_error <= 1'b1;
			end
			default: ;
		endcase
	end
endmodule

FILE: sv/bbsa_divider.sv
// Restoring divider, one quotient bit per cycle.
module bbsa_divider (
	input  logic clk,
	input  logic arst_n,
	input  bbsa_pkg::div_req_t req,
	output logic busy,
	output logic done,
	output logic [bbsa_pkg::SUM_W-1:0] quotient
);
	localparam int W = bbsa_pkg::SUM_W;
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] rem_q, quo_q, den_q;
	logic [CW-1:0] cnt_q;
	logic [W:0] trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};
	assign busy = (cnt_q != '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				cnt_q <= CW'(W);
			end else if (busy) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end
endmodule

FILE: sv/bbsa_checker.sv
// Port-level checker for the summed-area box blur unit, with its bind.
module bbsa_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic query_error,
	input logic [7:0] blur_red,
	input logic [7:0] kept_alpha
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(blur_red) && $stable(query_error))
		else $error("stalled result changed");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && query_error |-> blur_red == 8'd0 && kept_alpha == 8'd0)
		else $error("error result carries data");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while busy");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("request accepted with a result waiting");
endmodule

bind box_blur_summed_area_unit bbsa_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .query_error(query_error), .blur_red(blur_red),
	.kept_alpha(kept_alpha));

FILE: tb/tb_box_blur_summed_area_unit.sv
// Self-checking testbench for the summed-area box blur unit.
`timescale 1ns / 100ps

module tb_box_blur_summed_area_unit;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 120;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic err;
	} blur_res_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_QUERY} row_kind_t;

	typedef struct {
		row_kind_t kind;
		int f0, f1, f2, f3;
		logic typed;
		blur_res_t res;
	} stim_row_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [bbsa_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bbsa_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid, in_stall;
	logic req_type;
	logic [7:0] pixel_red, pixel_green, pixel_blue, pixel_alpha, query_row, query_col;
	logic out_valid, out_stall;
	logic [7:0] blur_red, blur_green, blur_blue, kept_alpha;
	logic query_error;

	box_blur_summed_area_unit DUT (.*);

	// Own copy of the block's state.
	logic [23:0] area_sum [3][65536];
	logic [7:0] alpha_mem [65536];
	logic [23:0] run_sum [3];
	int ld_row, ld_col;
	logic [8:0] reg_width, reg_height;
	logic [7:0] reg_window;
	bit fill_started;

	blur_res_t blur_queue [$];
	int cycles;
	int errors;
	bit quiet;
	int hold_left;
	bit hold_trig;

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int clamp_dim(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void apply_load(logic [7:0] r, g, b, a);
		int w, h, addr_now;
		logic [7:0] px [3];
		logic [23:0] above;
		w = clamp_dim(int'(reg_width), 256);
		h = clamp_dim(int'(reg_height), 256);
		px[0] = r; px[1] = g; px[2] = b;
		if (ld_row >= h || ld_col >= w) begin
			ld_row = 0;
			ld_col = 0;
		end
		if (ld_row == 0 && ld_col == 0)
			fill_started = 1'b1;
		addr_now = ld_row * 256 + ld_col;
		for (int k = 0; k < 3; k++) begin
			if (ld_col == 0)
				run_sum[k] = '0;
			run_sum[k] = run_sum[k] + 24'(px[k]);
			above = (ld_row > 0) ? area_sum[k][addr_now - 256] : 24'd0;
			area_sum[k][addr_now] = run_sum[k] + above;
		end
		alpha_mem[addr_now] = a;
		if (ld_col + 1 >= w) begin
			ld_col = 0;
			ld_row = (ld_row + 1 >= h) ? 0 : ld_row + 1;
		end else begin
			ld_col++;
		end
	endfunction

	function automatic blur_res_t blur_at(int row, int col);
		blur_res_t res;
		int w, h, s, r0, r1, c0, c1, n;
		logic [23:0] total;
		logic [31:0] q;
		w = clamp_dim(int'(reg_width), 256);
		h = clamp_dim(int'(reg_height), 256);
		s = clamp_dim(int'(reg_window), 200);
		res = '0;
		if (row >= h || col >= w) begin
			res.err = 1'b1;
			return res;
		end
		r0 = (row + 1 > s) ? row + 1 - s : 0;
		c0 = (col + 1 > s) ? col + 1 - s : 0;
		r1 = (row + s - 1 < h) ? row + s - 1 : h - 1;
		c1 = (col + s - 1 < w) ? col + s - 1 : w - 1;
		n = (r1 - r0 + 1) * (c1 - c0 + 1);
		for (int k = 0; k < 3; k++) begin
			total = area_sum[k][r1 * 256 + c1];
			if (c0 > 0) total = total - area_sum[k][r1 * 256 + c0 - 1];
			if (r0 > 0) total = total - area_sum[k][(r0 - 1) * 256 + c1];
			if (r0 > 0 && c0 > 0) total = total + area_sum[k][(r0 - 1) * 256 + c0 - 1];
			q = 32'(total) / 32'(n);
			if (k == 0) res.red = q[7:0];
			else if (k == 1) res.green = q[7:0];
			else res.blue = q[7:0];
		end
		res.alpha = alpha_mem[row * 256 + col];
		return res;
	endfunction

	// Offers one request and waits until the block takes it.
	task automatic send_req(logic typ, logic [7:0] r, g, b, a, row, col,
			logic typed = 1'b0, blur_res_t res = '0);
		in_valid <= 1'b1;
		req_type <= typ;
		pixel_red <= r; pixel_green <= g; pixel_blue <= b; pixel_alpha <= a;
		query_row <= row; query_col <= col;
		do @(posedge clk); while (in_stall);
		if (typ == bbsa_pkg::REQ_LOAD)
			apply_load(r, g, b, a);
		else
			blur_queue.push_back(typed ? res : blur_at(int'(row), int'(col)));
		if (!quiet && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic send_pixel();
		send_req(bbsa_pkg::REQ_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Registers change only once the block has gone quiet.
	task automatic write_regs(int w, int h, int s);
		in_valid <= 1'b0;
		while (blur_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1; cfg_index <= bbsa_pkg::REG_WIDTH; cfg_data <= 9'(w);
		@(posedge clk);
		cfg_index <= bbsa_pkg::REG_HEIGHT; cfg_data <= 9'(h);
		@(posedge clk);
		cfg_index <= bbsa_pkg::REG_WINDOW; cfg_data <= 9'(s);
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_width = 9'(w);
		reg_height = 9'(h);
		reg_window = 8'(s);
	endtask

	// Loads pixels until a whole image has been written from the top-left pixel on,
	// so that no query reads an unwritten sum.
	task automatic fill_image();
		fill_started = 1'b0;
		do send_pixel(); while (!(fill_started && ld_row == 0 && ld_col == 0));
	endtask

	task automatic random_phase(int w, int h, int s, int count);
		int iw, ih;
		write_regs(w, h, s);
		fill_image();
		iw = clamp_dim(w, 256);
		ih = clamp_dim(h, 256);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				hold_trig = 1'b1;
			if ($urandom_range(99) < 30)
				send_pixel();
			else if ($urandom_range(99) < 15)
				send_req(bbsa_pkg::REQ_QUERY, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom));
			else
				send_req(bbsa_pkg::REQ_QUERY, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom_range(ih - 1)), 8'($urandom_range(iw - 1)));
		end
	endtask

	stim_row_t directed [] = '{
		'{ROW_CFG, 2, 2, 1, 0, 1'b0, '0},
		'{ROW_LOAD, 255, 255, 255, 255, 1'b0, '0},
		'{ROW_LOAD, 0, 0, 0, 0, 1'b0, '0},
		'{ROW_LOAD, 1, 2, 3, 4, 1'b0, '0},
		'{ROW_LOAD, 200, 100, 50, 25, 1'b0, '0},
		'{ROW_QUERY, 0, 0, 0, 0, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0}},
		'{ROW_QUERY, 1, 1, 0, 0, 1'b1, '{8'd200, 8'd100, 8'd50, 8'd25, 1'b0}},
		'{ROW_QUERY, 2, 0, 0, 0, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b1}},
		'{ROW_QUERY, 0, 255, 0, 0, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b1}},
		'{ROW_QUERY, 255, 255, 0, 0, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b1}},
		'{ROW_CFG, 2, 2, 200, 0, 1'b0, '0},
		'{ROW_QUERY, 0, 0, 0, 0, 1'b0, '0},
		'{ROW_QUERY, 1, 0, 0, 0, 1'b0, '0},
		'{ROW_CFG, 0, 0, 0, 0, 1'b0, '0},
		'{ROW_LOAD, 9, 8, 7, 6, 1'b0, '0},
		'{ROW_QUERY, 0, 0, 0, 0, 1'b1, '{8'd9, 8'd8, 8'd7, 8'd6, 1'b0}},
		'{ROW_QUERY, 0, 1, 0, 0, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b1}}
	};

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = bbsa_pkg::REG_WIDTH; cfg_data = '0;
		in_valid = 1'b0; req_type = bbsa_pkg::REQ_LOAD;
		pixel_red = '0; pixel_green = '0; pixel_blue = '0; pixel_alpha = '0;
		query_row = '0; query_col = '0;
		reg_width = 9'd256; reg_height = 9'd256; reg_window = 8'd1;
		ld_row = 0; ld_col = 0;
		run_sum = '{24'd0, 24'd0, 24'd0};
		errors = 0; quiet = 1'b0; hold_trig = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			case (directed[i].kind)
				ROW_CFG: write_regs(directed[i].f0, directed[i].f1, directed[i].f2);
				ROW_LOAD: send_req(bbsa_pkg::REQ_LOAD, 8'(directed[i].f0), 8'(directed[i].f1),
					8'(directed[i].f2), 8'(directed[i].f3), 8'($urandom), 8'($urandom));
				default: send_req(bbsa_pkg::REQ_QUERY, 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 8'(directed[i].f0), 8'(directed[i].f1),
					directed[i].typed, directed[i].res);
			endcase
		end

		random_phase(5, 4, 2, 30);
		quiet = 1'b1;
		random_phase($urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(6, 1), 30);
		quiet = 1'b0;
		random_phase(511, 1, 255, 16);
		random_phase($urandom_range(6, 1), $urandom_range(6, 1), $urandom_range(8, 0), 20);

		in_valid <= 1'b0;
		while (blur_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Result side: random stalls plus a long hold-off in each random phase to back the block up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (hold_trig && hold_left == 0) begin
				hold_trig = 1'b0;
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				if (hold_left > 0)
					hold_left <= hold_left - 1;
				out_stall <= (hold_left > 1) || (!quiet && $urandom_range(99) < 14);
			end
			if (out_valid && !out_stall) begin
				if (blur_queue.size() == 0) begin
					$display("%0t: unexpected result %h", $time,
						{blur_red, blur_green, blur_blue, kept_alpha, query_error});
					errors++;
				end else begin
					blur_res_t want;
					want = blur_queue.pop_front();
					if (blur_red !== want.red) begin
						$display("%0t: blur_red exp %0d got %0d", $time, want.red, blur_red);
						errors++;
					end
					if (blur_green !== want.green) begin
						$display("%0t: blur_green exp %0d got %0d", $time, want.green,
							blur_green);
						errors++;
					end
					if (blur_blue !== want.blue) begin
						$display("%0t: blur_blue exp %0d got %0d", $time, want.blue, blur_blue);
						errors++;
					end
					if (kept_alpha !== want.alpha) begin
						$display("%0t: kept_alpha exp %0d got %0d", $time, want.alpha,
							kept_alpha);
						errors++;
					end
					if (query_error !== want.err) begin
						$display("%0t: query_error exp %0d got %0d", $time, want.err,
							query_error);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial cycles = 0;

endmodule
